>>> hdl/smq_pkg.sv
// Package for the SmoothQuant scale factor core: widths, constants, payload types
// and the elaboration-time coefficient function used by the exp2 pipeline.
// Depends on nothing.
package smq_pkg;

    localparam int FRAC_W     = 16;
    localparam int LOG_STEPS  = FRAC_W;
    localparam int EXP_STEPS  = FRAC_W;
    localparam int LOG_W      = 5 + FRAC_W;
    localparam int MANT_W     = 31;
    localparam int SIDE_A_LEN = LOG_STEPS + 2;
    localparam int SIDE_B_LEN = EXP_STEPS;
    localparam int LATENCY    = LOG_STEPS + EXP_STEPS + 4;

    localparam logic [20:0] SCALE_ONE   = 21'd65536;
    localparam logic [20:0] SCALE_MIN   = 21'd4096;
    localparam logic [20:0] SCALE_MAX   = 21'd1048576;
    localparam logic [15:0] ALPHA_RESET = 16'd32768;

    typedef struct packed {
        logic [31:0] act_abs_max;
        logic [31:0] wgt_abs_max;
        logic        stats_present;
        logic        last_channel;
    } t_in;

    typedef struct packed {
        logic [20:0] smooth_scale;
        logic        last_channel_out;
    } t_out;

    typedef enum logic [1:0] {
        CLS_EXP = 2'd0,
        CLS_ONE = 2'd1,
        CLS_MIN = 2'd2,
        CLS_MAX = 2'd3
    } t_cls;

    function automatic logic [63:0] isqrt64(input logic [63:0] v);
        logic [63:0] rem;
        logic [63:0] res;
        logic [63:0] b;
        rem = v;
        res = 64'd0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + b) begin
                rem = rem - (res + b);
                res = (res >> 1) + b;
            end else begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Coefficient for fraction bit k: the 2^k-th root of two in Q.30.
    function automatic logic [31:0] exp2_coef(input int k);
        logic [63:0] c;
        c = 64'd1 << 31;
        for (int j = 1; j <= FRAC_W; j++) begin
            if (j <= k) begin
                c = isqrt64(c << 30);
            end
        end
        return c[31:0];
    endfunction

endpackage

>>> hdl/smq_log2.sv
// Pipelined integer log2 in Q5.16: one normalising stage, then one squaring
// stage per fraction bit. Depends on smq_pkg.
module smq_log2 (
    input  logic                     i_clk,
    input  logic [31:0]              i_x,
    output logic [smq_pkg::LOG_W-1:0] o_log
);

    logic [31:0]               r_y  [0:smq_pkg::LOG_STEPS-1];
    logic [4:0]                r_n  [0:smq_pkg::LOG_STEPS];
    logic [smq_pkg::FRAC_W-1:0] r_fr [0:smq_pkg::LOG_STEPS];
    logic [4:0]                w_top;

    always_comb begin
        w_top = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (i_x[i]) begin
                w_top = 5'(i);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y[0]  <= i_x << (5'd31 - w_top);
        r_n[0]  <= w_top;
        r_fr[0] <= '0;
    end

    for (genvar j = 1; j <= smq_pkg::LOG_STEPS; j++) begin : g_step
        logic [63:0] w_sq;
        logic [32:0] w_y2;
        assign w_sq = {32'd0, r_y[j-1]} * {32'd0, r_y[j-1]};
        assign w_y2 = w_sq[63:31];

        always_ff @(posedge i_clk) begin
            r_n[j]  <= r_n[j-1];
            r_fr[j] <= {r_fr[j-1][smq_pkg::FRAC_W-2:0], w_y2[32]};
        end

        if (j < smq_pkg::LOG_STEPS) begin : g_y
            always_ff @(posedge i_clk) begin
                r_y[j] <= w_y2[32] ? w_y2[32:1] : w_y2[31:0];
            end
        end
    end

    assign o_log = {r_n[smq_pkg::LOG_STEPS], r_fr[smq_pkg::LOG_STEPS]};

endmodule

>>> hdl/smq_exp2.sv
// Pipelined exp2 of a 16-bit fraction in Q.30: one constant multiply with
// rounding per fraction bit. Depends on smq_pkg.
module smq_exp2 (
    input  logic                        i_clk,
    input  logic [smq_pkg::FRAC_W-1:0]  i_frac,
    output logic [smq_pkg::MANT_W-1:0]  o_mant
);

    logic [smq_pkg::MANT_W-1:0] r_m [0:smq_pkg::EXP_STEPS-1];
    logic [smq_pkg::FRAC_W-1:0] r_f [0:smq_pkg::EXP_STEPS-2];

    for (genvar j = 0; j < smq_pkg::EXP_STEPS; j++) begin : g_step
        localparam logic [31:0] COEF = smq_pkg::exp2_coef(j + 1);
        logic [smq_pkg::MANT_W-1:0] w_m_in;
        logic [smq_pkg::FRAC_W-1:0] w_f_in;
        logic [63:0]                w_prod;

        if (j == 0) begin : g_first
            assign w_m_in = smq_pkg::MANT_W'(1) << 30;
            assign w_f_in = i_frac;
        end else begin : g_next
            assign w_m_in = r_m[j-1];
            assign w_f_in = r_f[j-1];
        end

        assign w_prod = {33'd0, w_m_in} * {32'd0, COEF} + (64'd1 << 29);

        always_ff @(posedge i_clk) begin
            r_m[j] <= w_f_in[smq_pkg::FRAC_W-1-j] ? w_prod[60:30] : w_m_in;
        end

        if (j < smq_pkg::EXP_STEPS - 1) begin : g_f
            always_ff @(posedge i_clk) begin
                r_f[j] <= w_f_in;
            end
        end
    end

    assign o_mant = r_m[smq_pkg::EXP_STEPS-1];

endmodule

>>> hdl/smoothquant_scale_factor_core.sv
// SmoothQuant scale factor core: a^alpha / w^(1-alpha) clamped to [1/16, 16].
// One transaction is taken every cycle. The pipeline is made of the normalising stage
// and 16 squaring stages of the log2 pipelines, the alpha multiply, the rounding stage,
// the 16-stage exp2 chain and the output.
// Synchronous reset clears the pipeline valid bits and sets alpha to one half.
// Results cannot be held off, so busy stays low and the pipeline never stalls.
module smoothquant_scale_factor_core (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  smq_pkg::t_in        i_item,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [15:0]         i_cfg_data,
    output logic                o_valid,
    output smq_pkg::t_out       o_result
);

    typedef struct packed {
        logic valid;
        logic present;
        logic azero;
        logic last;
    } t_side_a;

    typedef struct packed {
        logic          valid;
        smq_pkg::t_cls cls;
        logic [4:0]    shift;
        logic          last;
    } t_side_b;

    logic                          w_cfg_wr;
    logic [15:0]                   r_alpha_q;
    logic                          w_accept;
    logic [31:0]                   w_wgt;
    logic [smq_pkg::LOG_W-1:0]     w_log_a;
    logic [smq_pkg::LOG_W-1:0]     w_log_w;
    t_side_a                       r_sa [0:smq_pkg::SIDE_A_LEN-1];
    t_side_b                       r_sb [0:smq_pkg::SIDE_B_LEN];
    logic signed [39:0]            r_pa;
    logic signed [39:0]            r_pb;
    logic signed [21:0]            w_la;
    logic signed [21:0]            w_lw;
    logic [16:0]                   w_beta;
    logic signed [40:0]            w_t;
    logic signed [24:0]            w_t16;
    logic [18:0]                   w_v;
    t_side_b                       n_sb;
    logic [smq_pkg::FRAC_W-1:0]    r_frac;
    logic [smq_pkg::MANT_W-1:0]    w_mant;
    logic [31:0]                   w_round;
    logic [31:0]                   w_s;
    logic [20:0]                   n_scale;
    logic                          r_valid;
    smq_pkg::t_out                 r_result;

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign w_accept    = start && !busy;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alpha_q <= smq_pkg::ALPHA_RESET;
        end else if (w_cfg_wr) begin
            r_alpha_q <= i_cfg_data;
        end
    end

    assign w_wgt = (i_item.wgt_abs_max == 32'd0) ? 32'd1 : i_item.wgt_abs_max;

    smq_log2 u_log_a (
        .i_clk (i_clk),
        .i_x   (i_item.act_abs_max),
        .o_log (w_log_a)
    );

    smq_log2 u_log_w (
        .i_clk (i_clk),
        .i_x   (w_wgt),
        .o_log (w_log_w)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < smq_pkg::SIDE_A_LEN; i++) begin
                r_sa[i] <= '0;
            end
        end else begin
            r_sa[0].valid   <= w_accept;
            r_sa[0].present <= i_item.stats_present;
            r_sa[0].azero   <= (i_item.act_abs_max == 32'd0);
            r_sa[0].last    <= i_item.last_channel;
            for (int i = 1; i < smq_pkg::SIDE_A_LEN; i++) begin
                r_sa[i] <= r_sa[i-1];
            end
        end
    end

    assign w_la   = $signed({1'b0, w_log_a}) - 22'sd1048576;
    assign w_lw   = $signed({1'b0, w_log_w}) - 22'sd1048576;
    assign w_beta = 17'd65536 - {1'b0, r_alpha_q};

    always_ff @(posedge i_clk) begin
        r_pa <= 40'(w_la) * 40'($signed({2'b00, r_alpha_q}));
        r_pb <= 40'(w_lw) * 40'($signed({1'b0, w_beta}));
    end

    assign w_t   = {r_pa[39], r_pa} - {r_pb[39], r_pb} + 41'sd32768;
    assign w_t16 = w_t[40:16];
    assign w_v   = w_t16[18:0] + 19'h40000;

    always_comb begin
        n_sb.valid = r_sa[smq_pkg::SIDE_A_LEN-1].valid;
        n_sb.last  = r_sa[smq_pkg::SIDE_A_LEN-1].last;
        n_sb.shift = 5'd18 - {2'b00, w_v[18:16]};
        if (!r_sa[smq_pkg::SIDE_A_LEN-1].present) begin
            n_sb.cls = smq_pkg::CLS_ONE;
        end else if (r_sa[smq_pkg::SIDE_A_LEN-1].azero) begin
            n_sb.cls = smq_pkg::CLS_MIN;
        end else if (w_t16 <= -25'sd262144) begin
            n_sb.cls = smq_pkg::CLS_MIN;
        end else if (w_t16 >= 25'sd262144) begin
            n_sb.cls = smq_pkg::CLS_MAX;
        end else begin
            n_sb.cls = smq_pkg::CLS_EXP;
        end
    end

    always_ff @(posedge i_clk) begin
        r_frac <= w_v[15:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i <= smq_pkg::SIDE_B_LEN; i++) begin
                r_sb[i] <= '0;
            end
        end else begin
            r_sb[0] <= n_sb;
            for (int i = 1; i <= smq_pkg::SIDE_B_LEN; i++) begin
                r_sb[i] <= r_sb[i-1];
            end
        end
    end

    smq_exp2 u_exp (
        .i_clk  (i_clk),
        .i_frac (r_frac),
        .o_mant (w_mant)
    );

    assign w_round = {1'b0, w_mant} + (32'd1 << (r_sb[smq_pkg::SIDE_B_LEN].shift - 5'd1));
    assign w_s     = w_round >> r_sb[smq_pkg::SIDE_B_LEN].shift;

    always_comb begin
        case (r_sb[smq_pkg::SIDE_B_LEN].cls)
            smq_pkg::CLS_ONE: n_scale = smq_pkg::SCALE_ONE;
            smq_pkg::CLS_MIN: n_scale = smq_pkg::SCALE_MIN;
            smq_pkg::CLS_MAX: n_scale = smq_pkg::SCALE_MAX;
            smq_pkg::CLS_EXP: begin
                if (w_s < {11'd0, smq_pkg::SCALE_MIN}) begin
                    n_scale = smq_pkg::SCALE_MIN;
                end else if (w_s > {11'd0, smq_pkg::SCALE_MAX}) begin
                    n_scale = smq_pkg::SCALE_MAX;
                end else begin
                    n_scale = w_s[20:0];
                end
            end
            default: n_scale = smq_pkg::SCALE_ONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= r_sb[smq_pkg::SIDE_B_LEN].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_result.smooth_scale     <= n_scale;
        r_result.last_channel_out <= r_sb[smq_pkg::SIDE_B_LEN].last;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    a_out_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept && i_rst_n, smq_pkg::LATENCY))
        else $error("Result strobe without a matching input transaction.");

    a_out_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_result.smooth_scale >= smq_pkg::SCALE_MIN)
                 && (o_result.smooth_scale <= smq_pkg::SCALE_MAX))
        else $error("Scale factor outside the clamp range.");

    a_no_stats: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(w_accept && !i_item.stats_present, smq_pkg::LATENCY)
        |-> o_result.smooth_scale == smq_pkg::SCALE_ONE)
        else $error("Channel without stats did not give a scale of one.");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_result.last_channel_out == $past(i_item.last_channel, smq_pkg::LATENCY))
        else $error("Last-channel mark did not follow its transaction.");

endmodule
